### sv/htbd_pkg.sv
// ----------------------------------------------------------------------------
// htbd_pkg
// Shared constants and types for the Huffman tree bit decoder.
// ----------------------------------------------------------------------------
package htbd_pkg;

    localparam int NODE_DEPTH  = 512;
    localparam int SYMBOL_BITS = 8;
    localparam int ADDR_W      = $clog2(NODE_DEPTH);
    localparam int IDX_W       = 9;
    localparam int SYM_IN_W    = 8;
    localparam int SYM_OUT_W   = 8;
    localparam int BYTE_W      = 8;
    localparam int BIT_W       = 3;
    localparam int CNT_W       = 32;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_ROOT_NODE    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_SYMBOL_LIMIT = 1'b1;

    localparam logic MODE_NODE_WRITE = 1'b0;
    localparam logic MODE_DECODE     = 1'b1;

    typedef struct packed {
        logic                   leaf;
        logic [SYMBOL_BITS-1:0] sym;
        logic [IDX_W-1:0]       left;
        logic [IDX_W-1:0]       right;
    } t_node;

    localparam int NODE_W = $bits(t_node);

    typedef struct packed {
        logic node_wr;
        logic load_byte;
        logic rd_cur;
        logic step_child;
        logic emit;
        logic next_bit;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic ent_leaf;
        logic bit_last;
        logic limit_hit;
        logic limit_next;
        logic slot_free;
        logic pend_valid;
    } t_status;

endpackage

### sv/huffman_tree_bit_decoder.sv
// ----------------------------------------------------------------------------
// huffman_tree_bit_decoder
// Walks a Huffman code tree held in a node table and emits decoded symbols.
// ----------------------------------------------------------------------------
// A node write (mode 0) is done straight from idle. A compressed byte (mode 1)
// is accepted and then the walk position is read. Each bit then steps to the
// child and evaluates its entry, with a root read again when it ends on a
// leaf before the last bit. A root that is itself a leaf is read again and
// evaluated for each bit. A flush state then releases the last symbol, if
// any. The output can stall the walk, the symbol limit can end the byte
// early, and once the limit has already been reached a byte goes straight to
// the flush. Each tree step waits for the child's entry, since the node table
// has one read port with a registered read. The last symbol of a byte is held
// until the byte's bits are used up or the symbol limit is reached, so that it
// can carry last_of_byte.
module huffman_tree_bit_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [htbd_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [htbd_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_mode,
    input  logic [htbd_pkg::IDX_W-1:0]        i_node_index,
    input  logic                              i_node_is_leaf,
    input  logic [htbd_pkg::SYM_IN_W-1:0]     i_node_symbol,
    input  logic [htbd_pkg::IDX_W-1:0]        i_node_left,
    input  logic [htbd_pkg::IDX_W-1:0]        i_node_right,
    input  logic [htbd_pkg::BYTE_W-1:0]       i_data_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [htbd_pkg::SYM_OUT_W-1:0]    o_symbol,
    output logic                              o_last_of_byte,
    output logic                              o_message_done
);
    import htbd_pkg::*;

    t_cmd    cmd;
    t_status status;

    htbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_mode     (i_mode),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    htbd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_node_index   (i_node_index),
        .i_node_is_leaf (i_node_is_leaf),
        .i_node_symbol  (i_node_symbol),
        .i_node_left    (i_node_left),
        .i_node_right   (i_node_right),
        .i_data_byte    (i_data_byte),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_symbol       (o_symbol),
        .o_last_of_byte (o_last_of_byte),
        .o_message_done (o_message_done)
    );

    // no held symbol may remain once a new transaction can be taken
    a_ready_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !status.pend_valid)
        else $error("pending symbol left while accepting input");

    // a symbol moving to the output register never overwrites an untaken one
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit || cmd.flush) && status.pend_valid |-> !o_out_valid || i_out_ready)
        else $error("output register overwritten");

    // a tree step is always followed by evaluation, never by an idle accept
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step_child |=> !o_in_ready && !cmd.rd_cur)
        else $error("tree step not evaluated");

endmodule

### sv/htbd_ram.sv
// ----------------------------------------------------------------------------
// htbd_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module htbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/htbd_dp.sv
// ----------------------------------------------------------------------------
// htbd_dp
// Datapath: node table, walk position, symbol count, pending and output regs.
// ----------------------------------------------------------------------------
module htbd_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [htbd_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [htbd_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic [htbd_pkg::IDX_W-1:0]        i_node_index,
    input  logic                              i_node_is_leaf,
    input  logic [htbd_pkg::SYM_IN_W-1:0]     i_node_symbol,
    input  logic [htbd_pkg::IDX_W-1:0]        i_node_left,
    input  logic [htbd_pkg::IDX_W-1:0]        i_node_right,
    input  logic [htbd_pkg::BYTE_W-1:0]       i_data_byte,
    input  htbd_pkg::t_cmd                    i_cmd,
    output htbd_pkg::t_status                 o_status,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [htbd_pkg::SYM_OUT_W-1:0]    o_symbol,
    output logic                              o_last_of_byte,
    output logic                              o_message_done
);
    import htbd_pkg::*;

    logic [IDX_W-1:0]     r_root;
    logic [CNT_W-1:0]     r_limit;
    logic [CNT_W-1:0]     r_count;
    logic [IDX_W-1:0]     r_cur;
    logic [BYTE_W-1:0]    r_byte;
    logic [BIT_W-1:0]     r_bit;
    logic                 r_oob;
    logic                 r_pend_valid;
    logic [SYM_OUT_W-1:0] r_pend_sym;
    logic                 r_pend_done;
    logic                 r_out_valid;
    logic [SYM_OUT_W-1:0] r_out_sym;
    logic                 r_out_last;
    logic                 r_out_done;

    t_node              wr_node;
    t_node              ent;
    logic [NODE_W-1:0]  rdata;
    logic               wr_en;
    logic               rd_en;
    logic [IDX_W-1:0]   child;
    logic [IDX_W-1:0]   rd_idx;
    logic [CNT_W-1:0]   count_inc;
    logic               slot_free;
    logic               out_load;

    assign wr_node.leaf  = i_node_is_leaf;
    assign wr_node.sym   = SYMBOL_BITS'(i_node_symbol);
    assign wr_node.left  = i_node_left;
    assign wr_node.right = i_node_right;
    assign wr_en = i_cmd.node_wr && (32'(i_node_index) < 32'(NODE_DEPTH));

    assign ent    = r_oob ? '0 : t_node'(rdata);
    assign child  = r_byte[r_bit] ? ent.right : ent.left;
    assign rd_en  = i_cmd.rd_cur || i_cmd.step_child;
    assign rd_idx = i_cmd.step_child ? child : r_cur;

    htbd_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (ADDR_W'(i_node_index)),
        .i_wdata (wr_node),
        .i_re    (rd_en),
        .i_raddr (ADDR_W'(rd_idx)),
        .o_rdata (rdata)
    );

    assign count_inc = r_count + CNT_W'(1);
    assign slot_free = !r_out_valid || i_out_ready;
    assign out_load  = (i_cmd.emit && r_pend_valid) || (i_cmd.flush && r_pend_valid);

    assign o_status.ent_leaf   = ent.leaf;
    assign o_status.bit_last   = (r_bit == '0);
    assign o_status.limit_hit  = (r_count == r_limit);
    assign o_status.limit_next = (count_inc == r_limit);
    assign o_status.slot_free  = slot_free;
    assign o_status.pend_valid = r_pend_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root       <= '0;
            r_limit      <= '0;
            r_count      <= '0;
            r_cur        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_addr == REG_ROOT_NODE) begin
                r_root <= i_cfg_wdata[IDX_W-1:0];
                r_cur  <= i_cfg_wdata[IDX_W-1:0];
            end else if (i_cfg_we && i_cfg_addr == REG_SYMBOL_LIMIT) begin
                r_limit <= i_cfg_wdata;
                r_count <= '0;
                r_cur   <= r_root;
            end else if (i_cmd.emit) begin
                r_count <= count_inc;
                r_cur   <= r_root;
            end else if (i_cmd.step_child) begin
                r_cur <= child;
            end

            if (i_cmd.emit) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_valid <= 1'b0;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_byte <= i_data_byte;
            r_bit  <= BIT_W'(BYTE_W - 1);
        end else if (i_cmd.next_bit) begin
            r_bit <= r_bit - BIT_W'(1);
        end
        if (rd_en) begin
            r_oob <= (32'(rd_idx) >= 32'(NODE_DEPTH));
        end
        if (i_cmd.emit) begin
            r_pend_sym  <= SYM_OUT_W'(ent.sym);
            r_pend_done <= o_status.limit_next;
        end
        if (out_load) begin
            r_out_sym  <= r_pend_sym;
            r_out_done <= r_pend_done;
            r_out_last <= i_cmd.flush;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_symbol       = r_out_sym;
    assign o_last_of_byte = r_out_last;
    assign o_message_done = r_out_done;

endmodule

### sv/htbd_ctrl.sv
// ----------------------------------------------------------------------------
// htbd_ctrl
// Controller: sequences node reads, tree steps, symbol emission and flush.
// ----------------------------------------------------------------------------
module htbd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_mode,
    input  htbd_pkg::t_status i_status,
    output htbd_pkg::t_cmd    o_cmd
);
    import htbd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_EVAL  = 5'b00100,
        S_CHILD = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   emit_ok;
    logic   stop_emit;
    logic   stop_walk;

    assign emit_ok   = !i_status.pend_valid || i_status.slot_free;
    assign stop_emit = i_status.bit_last || i_status.limit_next;
    assign stop_walk = i_status.bit_last || i_status.limit_hit;

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_state    = r_state;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_mode == MODE_NODE_WRITE) begin
                        o_cmd.node_wr = 1'b1;
                    end else begin
                        o_cmd.load_byte = 1'b1;
                        n_state = i_status.limit_hit ? S_FLUSH : S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_cur = 1'b1;
                n_state      = S_EVAL;
            end
            S_EVAL: begin
                if (!i_status.ent_leaf) begin
                    o_cmd.step_child = 1'b1;
                    n_state          = S_CHILD;
                end else if (emit_ok) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.next_bit = 1'b1;
                    n_state        = stop_emit ? S_FLUSH : S_READ;
                end
            end
            S_CHILD: begin
                if (!i_status.ent_leaf) begin
                    o_cmd.next_bit = 1'b1;
                    n_state        = stop_walk ? S_FLUSH : S_EVAL;
                end else if (emit_ok) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.next_bit = 1'b1;
                    n_state        = stop_emit ? S_FLUSH : S_READ;
                end
            end
            S_FLUSH: begin
                if (!i_status.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_status.slot_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
